FILE: design/heartbeat_pulse_brightness_assert.svh
// Assertion helpers shared by the design files.
`ifndef HEARTBEAT_PULSE_BRIGHTNESS_ASSERT_SVH
`define HEARTBEAT_PULSE_BRIGHTNESS_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HPB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HPB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/hpb_pkg.sv
`timescale 1ns / 1ps

package hpb_pkg;

    localparam int HPB_LED_COUNT   = 5;
    localparam int HPB_QUEUE_DEPTH = 4;

    localparam int TIME_W     = 32;
    localparam int LEN_W      = 16;
    localparam int CLR_W      = 8;
    localparam int LED_IDX_W  = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HUE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SATURATION = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CYCLE      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_LEN  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PULSE_OFS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BASE       = 3'd6;

    localparam logic [CLR_W-1:0] RST_HUE        = 8'h77;
    localparam logic [CLR_W-1:0] RST_SATURATION = 8'd255;
    localparam logic             RST_REVERSE    = 1'b1;
    localparam logic [LEN_W-1:0] RST_CYCLE      = 16'd1500;
    localparam logic [LEN_W-1:0] RST_PULSE_LEN  = 16'd150;
    localparam logic [LEN_W-1:0] RST_PULSE_OFS  = 16'd200;
    localparam logic [CLR_W-1:0] RST_BASE       = 8'd10;

    typedef struct packed {
        logic [CLR_W-1:0] hue;
        logic [CLR_W-1:0] sat;
        logic             rev;
        logic [LEN_W-1:0] cyc;
        logic [LEN_W-1:0] plen;
        logic [LEN_W-1:0] poff;
        logic [CLR_W-1:0] base;
    } t_cfg;

    // One LED's work: its two sample times and where it sits in the strip.
    typedef struct packed {
        logic [LED_IDX_W-1:0] led;
        logic                 last;
        logic [TIME_W-1:0]    t_a;
        logic [TIME_W-1:0]    t_b;
    } t_job;

endpackage

FILE: design/heartbeat_pulse_brightness.sv
`timescale 1ns / 1ps
// Throughput: one LED colour word per cycle while the queue has room and the output is not stalled,
// set by the LED walk in the front end; a new time word is taken as the last LED of the previous
// one is queued. A colour word passes through the queue, 16 stages of remainder at two bits each,
// the triangle stage, 4 divide stages and the output register.
// Reset (synchronous, active low) empties the queue and pipe and loads the default registers.
module heartbeat_pulse_brightness #(
    parameter int LED_COUNT   = hpb_pkg::HPB_LED_COUNT,
    parameter int QUEUE_DEPTH = hpb_pkg::HPB_QUEUE_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [hpb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hpb_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_time_valid,
    output logic                           o_time_ready,
    input  logic [hpb_pkg::TIME_W-1:0]     i_time_ms,
    output logic                           o_led_valid,
    input  logic                           i_led_ready,
    output logic [hpb_pkg::LED_IDX_W-1:0]  o_led_index,
    output logic [hpb_pkg::CLR_W-1:0]      o_hue_out,
    output logic [hpb_pkg::CLR_W-1:0]      o_saturation_out,
    output logic [hpb_pkg::CLR_W-1:0]      o_brightness,
    output logic                           o_last
);
    import hpb_pkg::*;

    t_cfg r_cfg;
    t_job w_push_job;
    t_job w_pop_job;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.hue  <= RST_HUE;
            r_cfg.sat  <= RST_SATURATION;
            r_cfg.rev  <= RST_REVERSE;
            r_cfg.cyc  <= RST_CYCLE;
            r_cfg.plen <= RST_PULSE_LEN;
            r_cfg.poff <= RST_PULSE_OFS;
            r_cfg.base <= RST_BASE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_HUE:        r_cfg.hue  <= i_cfg_data[CLR_W-1:0];
                REG_SATURATION: r_cfg.sat  <= i_cfg_data[CLR_W-1:0];
                REG_REVERSE:    r_cfg.rev  <= i_cfg_data[0];
                REG_CYCLE:      r_cfg.cyc  <= i_cfg_data[LEN_W-1:0];
                REG_PULSE_LEN:  r_cfg.plen <= i_cfg_data[LEN_W-1:0];
                REG_PULSE_OFS:  r_cfg.poff <= i_cfg_data[LEN_W-1:0];
                REG_BASE:       r_cfg.base <= i_cfg_data[CLR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    hpb_front #(
        .LED_COUNT (LED_COUNT)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_time_valid (i_time_valid),
        .o_time_ready (o_time_ready),
        .i_time_ms    (i_time_ms),
        .i_cfg        (r_cfg),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_push_job)
    );

    hpb_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_pop_job),
        .o_empty (w_empty)
    );

    hpb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (r_cfg),
        .i_empty          (w_empty),
        .i_job            (w_pop_job),
        .o_pop            (w_pop),
        .o_led_valid      (o_led_valid),
        .i_led_ready      (i_led_ready),
        .o_led_index      (o_led_index),
        .o_hue_out        (o_hue_out),
        .o_saturation_out (o_saturation_out),
        .o_brightness     (o_brightness),
        .o_last           (o_last)
    );

endmodule

FILE: design/hpb_front.sv
`timescale 1ns / 1ps

module hpb_front #(
    parameter int LED_COUNT = hpb_pkg::HPB_LED_COUNT
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_time_valid,
    output logic                      o_time_ready,
    input  logic [hpb_pkg::TIME_W-1:0] i_time_ms,
    input  hpb_pkg::t_cfg             i_cfg,
    input  logic                      i_full,
    output logic                      o_push,
    output hpb_pkg::t_job             o_job
);
    import hpb_pkg::*;

    localparam int CNT_W     = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int MAX_SHIFT = (LED_COUNT / 2) * (LED_COUNT - 1);
    localparam int SHIFT_W   = (MAX_SHIFT > 1) ? $clog2(MAX_SHIFT + 1) : 1;

    logic                r_busy;
    logic [CNT_W-1:0]    r_led;
    logic [SHIFT_W-1:0]  r_shift;
    logic [TIME_W-1:0]   r_time;
    logic                w_done;
    logic                w_accept;
    logic [TIME_W-1:0]   w_t_a;

    assign o_push       = r_busy && !i_full;
    assign w_done       = o_push && (r_led == CNT_W'(LED_COUNT - 1));
    assign o_time_ready = !r_busy || w_done;
    assign w_accept     = i_time_valid && o_time_ready;

    assign w_t_a = i_cfg.rev ? (r_time - TIME_W'(r_shift)) : (r_time + TIME_W'(r_shift));

    always_comb begin
        o_job.led  = LED_IDX_W'(r_led);
        o_job.last = (r_led == CNT_W'(LED_COUNT - 1));
        o_job.t_a  = w_t_a;
        o_job.t_b  = w_t_a + TIME_W'(i_cfg.poff);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (w_accept) begin
            r_busy <= 1'b1;
        end else if (w_done) begin
            r_busy <= 1'b0;
        end
    end

    // A new word restarts the LED walk; otherwise each push moves one LED on.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_time  <= i_time_ms;
            r_led   <= '0;
            r_shift <= '0;
        end else if (o_push) begin
            r_led   <= r_led + CNT_W'(1);
            r_shift <= r_shift + SHIFT_W'(LED_COUNT / 2);
        end
    end

endmodule

FILE: design/hpb_fifo.sv
`timescale 1ns / 1ps
`include "heartbeat_pulse_brightness_assert.svh"

module hpb_fifo #(
    parameter int DEPTH = hpb_pkg::HPB_QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  hpb_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output hpb_pkg::t_job o_data,
    output logic          o_empty
);
    import hpb_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wptr;
    logic [AW-1:0] r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    function automatic logic [AW-1:0] next_ptr(logic [AW-1:0] p);
        return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= next_ptr(r_wptr);
            end
            if (i_pop) begin
                r_rptr <= next_ptr(r_rptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    `HPB_ASSERT_IMPL(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "push into full queue")
    `HPB_ASSERT_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "pop from empty queue")

endmodule

FILE: design/hpb_back.sv
`timescale 1ns / 1ps
`include "heartbeat_pulse_brightness_assert.svh"

module hpb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hpb_pkg::t_cfg                 i_cfg,
    input  logic                          i_empty,
    input  hpb_pkg::t_job                 i_job,
    output logic                          o_pop,
    output logic                          o_led_valid,
    input  logic                          i_led_ready,
    output logic [hpb_pkg::LED_IDX_W-1:0] o_led_index,
    output logic [hpb_pkg::CLR_W-1:0]     o_hue_out,
    output logic [hpb_pkg::CLR_W-1:0]     o_saturation_out,
    output logic [hpb_pkg::CLR_W-1:0]     o_brightness,
    output logic                          o_last
);
    import hpb_pkg::*;

    localparam int MOD_STEP   = 2;
    localparam int MOD_STAGES = TIME_W / MOD_STEP;
    localparam int HALF_W     = LEN_W - 1;
    localparam int NUM_W      = HALF_W + CLR_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = CLR_W / DIV_STEP;
    localparam logic [CLR_W-1:0] FULL_ON = 8'd255;

    // Both pulse samples of one LED travel side by side as two lanes.
    typedef struct packed {
        logic [LED_IDX_W-1:0]        led;
        logic                        last;
        logic [1:0][LEN_W-1:0]       rem;
        logic [1:0][TIME_W-1:0]      dvd;
    } t_mod_st;

    typedef struct packed {
        logic [LED_IDX_W-1:0]        led;
        logic                        last;
        logic [1:0]                  byp;
        logic [1:0][CLR_W-1:0]       bval;
        logic [1:0][HALF_W-1:0]      rem;
        logic [1:0][CLR_W-1:0]       qlo;
    } t_div_st;

    t_mod_st                 r_ms [MOD_STAGES];
    t_mod_st                 n_ms [MOD_STAGES];
    logic [MOD_STAGES-1:0]   r_ms_vld;
    t_div_st                 r_tr;
    t_div_st                 n_tr;
    logic                    r_tr_vld;
    t_div_st                 r_dv [DIV_STAGES];
    t_div_st                 n_dv [DIV_STAGES];
    logic [DIV_STAGES-1:0]   r_dv_vld;
    logic                    r_out_vld;
    logic [LED_IDX_W-1:0]    r_out_led;
    logic [CLR_W-1:0]        r_out_hue;
    logic [CLR_W-1:0]        r_out_sat;
    logic [CLR_W-1:0]        r_out_bri;
    logic                    r_out_last;

    logic                    w_adv;
    logic [LEN_W-1:0]        w_div;
    logic [HALF_W-1:0]       w_half;
    t_mod_st                 w_in;
    logic [CLR_W-1:0]        w_va;
    logic [CLR_W-1:0]        w_vb;
    logic [CLR_W:0]          w_sum;

    // The whole pipe moves together whenever the output register can take a word.
    assign w_adv  = !r_out_vld || i_led_ready;
    assign o_pop  = w_adv && !i_empty;
    assign w_div  = (i_cfg.cyc == '0) ? LEN_W'(1) : i_cfg.cyc;
    assign w_half = i_cfg.plen[LEN_W-1:1];

    // Restoring remainder, one dividend bit per step.
    function automatic t_mod_st mod_advance(t_mod_st s, logic [LEN_W-1:0] d);
        t_mod_st        o;
        logic [LEN_W:0] r;
        o = s;
        for (int l = 0; l < 2; l++) begin
            for (int j = 0; j < MOD_STEP; j++) begin
                r = {o.rem[l], o.dvd[l][TIME_W-1]};
                o.dvd[l] = {o.dvd[l][TIME_W-2:0], 1'b0};
                if (r >= {1'b0, d}) begin
                    r = r - {1'b0, d};
                end
                o.rem[l] = r[LEN_W-1:0];
            end
        end
        return o;
    endfunction

    // Long division by half: dividend bits shift out of qlo as quotient bits shift in.
    function automatic t_div_st div_advance(t_div_st s, logic [HALF_W-1:0] h);
        t_div_st         o;
        logic [HALF_W:0] r;
        logic            q;
        o = s;
        for (int l = 0; l < 2; l++) begin
            for (int j = 0; j < DIV_STEP; j++) begin
                r = {o.rem[l], o.qlo[l][CLR_W-1]};
                q = (r >= {1'b0, h});
                if (q) begin
                    r = r - {1'b0, h};
                end
                o.qlo[l] = {o.qlo[l][CLR_W-2:0], q};
                o.rem[l] = r[HALF_W-1:0];
            end
        end
        return o;
    endfunction

    always_comb begin
        w_in.led    = i_job.led;
        w_in.last   = i_job.last;
        w_in.rem    = '0;
        w_in.dvd[0] = i_job.t_a;
        w_in.dvd[1] = i_job.t_b;
        n_ms[0] = mod_advance(w_in, w_div);
        for (int k = 1; k < MOD_STAGES; k++) begin
            n_ms[k] = mod_advance(r_ms[k-1], w_div);
        end
    end

    always_comb begin : p_tri
        logic [LEN_W-1:0]  ph;
        logic [LEN_W-1:0]  dif;
        logic [HALF_W-1:0] sel;
        logic [NUM_W-1:0]  num;
        n_tr.led  = r_ms[MOD_STAGES-1].led;
        n_tr.last = r_ms[MOD_STAGES-1].last;
        for (int l = 0; l < 2; l++) begin
            ph  = r_ms[MOD_STAGES-1].rem[l];
            dif = i_cfg.plen - ph;
            sel = (ph <= {1'b0, w_half}) ? ph[HALF_W-1:0] : dif[HALF_W-1:0];
            // Times 255 as a shift and a subtract.
            num = {sel, {CLR_W{1'b0}}} - {{CLR_W{1'b0}}, sel};
            if (ph > i_cfg.plen) begin
                n_tr.byp[l]  = 1'b1;
                n_tr.bval[l] = i_cfg.base;
            end else if (w_half == '0) begin
                n_tr.byp[l]  = 1'b1;
                n_tr.bval[l] = FULL_ON;
            end else begin
                n_tr.byp[l]  = 1'b0;
                n_tr.bval[l] = '0;
            end
            n_tr.rem[l] = num[NUM_W-1:CLR_W];
            n_tr.qlo[l] = num[CLR_W-1:0];
        end
    end

    always_comb begin
        n_dv[0] = div_advance(r_tr, w_half);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_dv[k] = div_advance(r_dv[k-1], w_half);
        end
    end

    assign w_va  = r_dv[DIV_STAGES-1].byp[0] ? r_dv[DIV_STAGES-1].bval[0]
                                             : r_dv[DIV_STAGES-1].qlo[0];
    assign w_vb  = r_dv[DIV_STAGES-1].byp[1] ? r_dv[DIV_STAGES-1].bval[1]
                                             : r_dv[DIV_STAGES-1].qlo[1];
    assign w_sum = {1'b0, w_va} + {1'b0, w_vb};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ms_vld  <= '0;
            r_tr_vld  <= 1'b0;
            r_dv_vld  <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_ms_vld  <= {r_ms_vld[MOD_STAGES-2:0], o_pop};
            r_tr_vld  <= r_ms_vld[MOD_STAGES-1];
            r_dv_vld  <= {r_dv_vld[DIV_STAGES-2:0], r_tr_vld};
            r_out_vld <= r_dv_vld[DIV_STAGES-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_ms       <= n_ms;
            r_tr       <= n_tr;
            r_dv       <= n_dv;
            r_out_led  <= r_dv[DIV_STAGES-1].led;
            r_out_last <= r_dv[DIV_STAGES-1].last;
            r_out_hue  <= i_cfg.hue;
            r_out_sat  <= i_cfg.sat;
            r_out_bri  <= w_sum[CLR_W] ? FULL_ON : w_sum[CLR_W-1:0];
        end
    end

    assign o_led_valid      = r_out_vld;
    assign o_led_index      = r_out_led;
    assign o_hue_out        = r_out_hue;
    assign o_saturation_out = r_out_sat;
    assign o_brightness     = r_out_bri;
    assign o_last           = r_out_last;

    `HPB_ASSERT_IMPL(a_no_pop_stalled, i_clk, i_rst_n, r_out_vld && !i_led_ready, !o_pop, "pop while output stalled")
    `HPB_ASSERT_NEXT(a_pipe_frozen, i_clk, i_rst_n, !w_adv, $stable(r_ms_vld) && $stable(r_dv_vld), "pipe moved while stalled")

endmodule
